// File: rtl/core/fpfa_pkg.sv
// Shared types, codes and default sizes for the fixed partition fit allocator.
package fpfa_pkg;

  localparam int unsigned NUM_PARTITIONS = 64;
  localparam int unsigned SIZE_BITS      = 16;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned SizeKbW = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 8;
  localparam int unsigned PolicyW = 2;
  localparam int unsigned PiuW    = 7;

  localparam logic [ModeW-1:0] MODE_LOAD    = 2'd0;
  localparam logic [ModeW-1:0] MODE_ALLOC   = 2'd1;
  localparam logic [ModeW-1:0] MODE_RESTART = 2'd2;

  localparam logic [PolicyW-1:0] FIT_FIRST = 2'd0;
  localparam logic [PolicyW-1:0] FIT_BEST  = 2'd1;
  localparam logic [PolicyW-1:0] FIT_WORST = 2'd2;

  localparam logic [StatusW-1:0] STATUS_DONE   = 2'd0;
  localparam logic [StatusW-1:0] STATUS_PLACED = 2'd1;
  localparam logic [StatusW-1:0] STATUS_NOFIT  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_FIT_POLICY = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_PARTS_USED = 4'd1;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_RESTART = 4'b0010,
    ST_SCAN    = 4'b0100,
    ST_DONE    = 4'b1000
  } state_e;

endpackage

// File: rtl/core/fpfa_item_if.sv
// Input item channel: mode, partition index and size.
interface fpfa_item_if;
  import fpfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [ModeW-1:0]   mode;
  logic [IndexW-1:0]  part_index;
  logic [SizeKbW-1:0] size_kb;

  modport source (output valid, mode, part_index, size_kb, input ready);
  modport sink   (input valid, mode, part_index, size_kb, output ready);
endinterface

// File: rtl/core/fpfa_result_if.sv
// Result channel: status, chosen partition and space left.
interface fpfa_result_if;
  import fpfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [IndexW-1:0]  chosen_partition;
  logic [SizeKbW-1:0] left_kb;

  modport source (output valid, status, chosen_partition, left_kb, input ready);
  modport sink   (input valid, status, chosen_partition, left_kb, output ready);
endinterface

// File: rtl/core/fpfa_cfg_if.sv
// Configuration write channel: register index and write data.
interface fpfa_cfg_if;
  import fpfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/fpfa_ram.sv
// Generic single write port RAM with one registered read port.
module fpfa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/fixed_partition_fit_allocator_top.sv
// Top level: partition tables, scan sequencer and shared fit compare unit.
// Load and unused modes go straight to done; allocate scans the first L partitions, restart
//   reloads all N remaining sizes; L = partitions in use (saturated), N = table size.
// One RAM read per partition per cycle through a single subtract/compare unit.
// A new item is taken only in idle, once the last result is out; a waiting result adds stalls.
// Reset clears occupancy, state and config registers; size tables stay undefined until loaded.
module fixed_partition_fit_allocator_top #(
  parameter int unsigned NumPartitions = fpfa_pkg::NUM_PARTITIONS,
  parameter int unsigned SizeBits      = fpfa_pkg::SIZE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fpfa_item_if.sink             in_i,
  fpfa_result_if.source         out_o,
  fpfa_cfg_if.sink              cfg_i
);
  import fpfa_pkg::*;

  localparam int unsigned AW = (NumPartitions > 1) ? $clog2(NumPartitions) : 1;
  localparam int unsigned CW = $clog2(NumPartitions + 1);
  localparam int unsigned SW = SizeBits;

  state_e             state_q, state_d;
  logic [CW-1:0]      issue_q, issue_d;
  logic               chk_vld_q, chk_vld_d;
  logic [AW-1:0]      chk_idx_q, chk_idx_d;
  logic [SW-1:0]      size_q, size_d;
  logic [CW-1:0]      limit_q, limit_d;
  logic               found_q, found_d;
  logic [AW-1:0]      pick_q, pick_d;
  logic [SW-1:0]      pick_left_q, pick_left_d;
  logic [NumPartitions-1:0] occ_q, occ_d;
  logic [StatusW-1:0] res_status_q, res_status_d;
  logic [AW-1:0]      res_part_q, res_part_d;
  logic [SW-1:0]      res_left_q, res_left_d;
  logic               out_vld_q, out_vld_d;
  logic [StatusW-1:0] out_status_q, out_status_d;
  logic [IndexW-1:0]  out_part_q, out_part_d;
  logic [SizeKbW-1:0] out_left_q, out_left_d;
  logic [PolicyW-1:0] policy_q;
  logic [PiuW-1:0]    piu_q;

  logic          orig_we;
  logic          rem_we;
  logic [AW-1:0] rem_waddr;
  logic [SW-1:0] rem_wdata;
  logic [SW-1:0] orig_rdata;
  logic [SW-1:0] rem_rdata;
  logic [SW:0]   diff;
  logic [SW-1:0] left;
  logic          fits;
  logic          better;
  logic          in_xfer;
  logic          scan_end;
  logic          rst_end;
  logic          load_ok;

  fpfa_ram #(.Width(SW), .Depth(NumPartitions)) u_orig_ram (
    .clk_i   (clk_i),
    .we_i    (orig_we),
    .waddr_i (AW'(in_i.part_index)),
    .wdata_i (SW'(in_i.size_kb)),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (orig_rdata)
  );

  fpfa_ram #(.Width(SW), .Depth(NumPartitions)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rem_waddr),
    .wdata_i (rem_wdata),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (rem_rdata)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign load_ok     = (int'(in_i.part_index) < NumPartitions);
  assign cfg_i.ready = 1'b1;

  assign diff     = {1'b0, rem_rdata} - {1'b0, size_q};
  assign left     = diff[SW-1:0];
  assign fits     = !diff[SW] && !occ_q[chk_idx_q];
  assign scan_end = (issue_q == limit_q) && !chk_vld_q;
  assign rst_end  = (issue_q == CW'(NumPartitions)) && !chk_vld_q;

  always_comb begin
    case (policy_q)
      FIT_BEST:  better = !found_q || (left < pick_left_q);
      FIT_WORST: better = !found_q || (left > pick_left_q);
      default:   better = !found_q;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    issue_d      = issue_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = issue_q[AW-1:0];
    size_d       = size_q;
    limit_d      = limit_q;
    found_d      = found_q;
    pick_d       = pick_q;
    pick_left_d  = pick_left_q;
    occ_d        = occ_q;
    res_status_d = res_status_q;
    res_part_d   = res_part_q;
    res_left_d   = res_left_q;
    orig_we      = 1'b0;
    rem_we       = 1'b0;
    rem_waddr    = AW'(in_i.part_index);
    rem_wdata    = SW'(in_i.size_kb);

    out_vld_d    = out_vld_q && !out_o.ready;
    out_status_d = out_status_q;
    out_part_d   = out_part_q;
    out_left_d   = out_left_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          size_d       = SW'(in_i.size_kb);
          issue_d      = '0;
          found_d      = 1'b0;
          res_status_d = STATUS_DONE;
          res_part_d   = '0;
          res_left_d   = '0;
          limit_d      = (int'(piu_q) > NumPartitions) ? CW'(NumPartitions) : CW'(piu_q);
          case (in_i.mode)
            MODE_LOAD: begin
              if (load_ok) begin
                orig_we = 1'b1;
                rem_we  = 1'b1;
                occ_d[AW'(in_i.part_index)] = 1'b0;
              end
              state_d = ST_DONE;
            end
            MODE_ALLOC: begin
              state_d = ST_SCAN;
            end
            MODE_RESTART: begin
              occ_d   = '0;
              state_d = ST_RESTART;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_RESTART: begin
        if (issue_q != CW'(NumPartitions)) begin
          chk_vld_d = 1'b1;
          issue_d   = issue_q + 1'b1;
        end
        if (chk_vld_q) begin
          rem_we    = 1'b1;
          rem_waddr = chk_idx_q;
          rem_wdata = orig_rdata;
        end
        if (rst_end) begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (issue_q != limit_q) begin
          chk_vld_d = 1'b1;
          issue_d   = issue_q + 1'b1;
        end
        if (chk_vld_q && fits && better) begin
          found_d     = 1'b1;
          pick_d      = chk_idx_q;
          pick_left_d = left;
        end
        if (scan_end) begin
          if (found_q) begin
            rem_we       = 1'b1;
            rem_waddr    = pick_q;
            rem_wdata    = pick_left_q;
            occ_d[pick_q] = 1'b1;
            res_status_d = STATUS_PLACED;
            res_part_d   = pick_q;
            res_left_d   = pick_left_q;
          end else begin
            res_status_d = STATUS_NOFIT;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_part_d   = IndexW'(res_part_q);
          out_left_d   = SizeKbW'(res_left_q);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issue_q   <= '0;
      chk_vld_q <= 1'b0;
      found_q   <= 1'b0;
      occ_q     <= '0;
      out_vld_q <= 1'b0;
      policy_q  <= FIT_FIRST;
      piu_q     <= '0;
    end else begin
      state_q   <= state_d;
      issue_q   <= issue_d;
      chk_vld_q <= chk_vld_d;
      found_q   <= found_d;
      occ_q     <= occ_d;
      out_vld_q <= out_vld_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_FIT_POLICY: policy_q <= cfg_i.data[PolicyW-1:0];
          REG_PARTS_USED: piu_q    <= cfg_i.data[PiuW-1:0];
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q    <= chk_idx_d;
    size_q       <= size_d;
    limit_q      <= limit_d;
    pick_q       <= pick_d;
    pick_left_q  <= pick_left_d;
    res_status_q <= res_status_d;
    res_part_q   <= res_part_d;
    res_left_q   <= res_left_d;
    out_status_q <= out_status_d;
    out_part_q   <= out_part_d;
    out_left_q   <= out_left_d;
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.status           = out_status_q;
  assign out_o.chosen_partition = out_part_q;
  assign out_o.left_kb          = out_left_q;

  a_restart_frees_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.mode == MODE_RESTART) |=> (occ_q == '0))
    else $error("restart left a partition occupied");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && chk_vld_q) |-> (CW'(chk_idx_q) < limit_q))
    else $error("scan checked a partition outside the searched range");

  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && scan_end && found_q) |-> (CW'(pick_q) < limit_q))
    else $error("chosen partition outside the searched range");

  a_no_read_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE || state_q == ST_IDLE) |-> !chk_vld_q)
    else $error("table read still in flight after the sequence ended");

  a_placed_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && scan_end && found_q) |=> occ_q[$past(pick_q)])
    else $error("placed partition not marked occupied");

endmodule
